// File: rtl/swm_pkg.sv
// Shared types and constants for the sliding window maximum block.
package swm_pkg;

    // Width of the window size register and its value after reset
    localparam int unsigned CFG_WIDTH    = 7;
    localparam int unsigned WINDOW_RESET = 3;

    // Per-cycle commands broadcast to every cell of the candidate chain
    typedef struct packed {
        logic step;   // an input transfer happens this cycle
        logic clr;    // the transferred sample starts a new sequence
        logic shift;  // every cell takes the contents of its right neighbor
    } t_cell_ctrl;

endpackage

// File: rtl/swm_cell.sv
// One cell of the candidate chain: holds one queue slot (value, age, valid).
module swm_cell
    import swm_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 32,
    parameter int unsigned AGE_WIDTH    = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctrl              i_ctrl,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [AGE_WIDTH-1:0]    i_window,
    input  logic                    i_prev_keep,
    input  logic                    i_right_valid,
    input  logic [SAMPLE_WIDTH-1:0] i_right_value,
    input  logic [AGE_WIDTH-1:0]    i_right_age,
    output logic                    o_keep,
    output logic                    o_stale,
    output logic                    o_expire,
    output logic                    o_pass_valid,
    output logic [SAMPLE_WIDTH-1:0] o_pass_value,
    output logic [AGE_WIDTH-1:0]    o_pass_age,
    output logic [SAMPLE_WIDTH-1:0] o_next_value
);

    logic                    r_valid;
    logic [SAMPLE_WIDTH-1:0] r_value;
    logic [AGE_WIDTH-1:0]    r_age;

    logic                    n_valid;
    logic [SAMPLE_WIDTH-1:0] n_value;
    logic [AGE_WIDTH-1:0]    n_age;

    logic [AGE_WIDTH:0]      age_inc;

    // Keep this candidate only if it beats the incoming sample
    assign o_keep  = r_valid && !i_ctrl.clr && ($signed(r_value) > $signed(i_sample));
    assign age_inc = {1'b0, r_age} + {{AGE_WIDTH{1'b0}}, 1'b1};

    // Front checks: already outside the window, or leaving it with this sample
    assign o_stale  = r_valid && ({1'b0, r_age} >= {1'b0, i_window});
    assign o_expire = o_keep && (age_inc >= {1'b0, i_window});

    // Contents after back removal and append, handed to the left neighbor
    always_comb begin
        o_pass_valid = r_valid;
        o_pass_value = r_value;
        o_pass_age   = r_age;
        if (i_ctrl.step) begin
            if (o_keep) begin
                o_pass_valid = 1'b1;
                o_pass_age   = age_inc[AGE_WIDTH-1:0];
            end else if (i_prev_keep) begin
                o_pass_valid = 1'b1;
                o_pass_value = i_sample;
                o_pass_age   = '0;
            end else begin
                o_pass_valid = 1'b0;
                o_pass_value = i_sample;
                o_pass_age   = '0;
            end
        end
    end

    // Take the right neighbor on a front drop, otherwise the contents after removal and append
    always_comb begin
        if (i_ctrl.shift) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
            n_age   = i_right_age;
        end else begin
            n_valid = o_pass_valid;
            n_value = o_pass_value;
            n_age   = o_pass_age;
        end
    end

    assign o_next_value = n_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

endmodule

// File: rtl/swm_obuf.sv
// Two-slot output buffer that decouples the result channel from the input side.
module swm_obuf
    import swm_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic                  o_space,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_slot [2];
    logic                  r_rd;
    logic                  r_wr;
    logic [1:0]            r_cnt;

    logic                  pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_space = (r_cnt != 2'd2);
    assign o_data  = r_slot[r_rd];
    assign pop     = o_valid && i_ready;

    // Advance pointers and count on each push and pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Store the pushed result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/sliding_window_maximum_top.sv
// Top level of the sliding window maximum: candidate cell chain and output buffer.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------
//  input    | i_valid / o_ready            | i_sample, i_starts_sequence
//  result   | o_valid / i_ready            | o_window_max
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_window_size
//
//  One input transfer per cycle while o_ready is high; a result is buffered
//  and shown in order. After the window is made smaller, the front cell drops
//  one stale candidate per cycle before o_ready rises again.
//  o_ready is also low while both output buffer slots hold results.
//  Synchronous reset empties the queue, clears the sample count, sets window 3.
//  The config port always takes a write (o_cfg_ready is high).
module sliding_window_maximum_top
    import swm_pkg::*;
#(
    parameter int unsigned WINDOW_MAX   = 64,
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_starts_sequence,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_window_max,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_WIDTH-1:0]    i_cfg_window_size
);

    localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
    localparam int unsigned EW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

    logic [CFG_WIDTH-1:0]    r_window_size;
    logic [CW-1:0]           r_seen;
    logic [CW-1:0]           n_seen;

    logic [EW-1:0]           cfg_ext;
    logic [EW-1:0]           win_ext;
    logic [CW-1:0]           win;

    t_cell_ctrl              ctrl;
    logic                    step;
    logic                    emit;
    logic                    space;
    logic [CW-1:0]           seen_base;

    logic [WINDOW_MAX-1:0]   keep;
    logic [WINDOW_MAX-1:0]   prev_keep;
    logic [WINDOW_MAX-1:0]   stale;
    logic [WINDOW_MAX-1:0]   expire;
    logic                    pass_valid [WINDOW_MAX+1];
    logic [SAMPLE_WIDTH-1:0] pass_value [WINDOW_MAX+1];
    logic [CW-1:0]           pass_age   [WINDOW_MAX+1];
    logic [SAMPLE_WIDTH-1:0] next_value [WINDOW_MAX];

    // Window register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CFG_WIDTH'(WINDOW_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_size <= i_cfg_window_size;
        end
    end

    // Clamp the window to 1..WINDOW_MAX
    assign cfg_ext = EW'(r_window_size);
    assign win_ext = (cfg_ext == '0) ? EW'(1) :
                     (cfg_ext > EW'(WINDOW_MAX)) ? EW'(WINDOW_MAX) : cfg_ext;
    assign win     = win_ext[CW-1:0];

    // Accept unless the front is stale or the output buffer is full
    assign o_ready    = !stale[0] && space;
    assign step       = i_valid && o_ready;
    assign ctrl.step  = step;
    assign ctrl.clr   = i_starts_sequence;
    assign ctrl.shift = step ? expire[0] : stale[0];

    // Neighbor links; the slot past the last cell takes the appended sample
    assign prev_keep = {keep[WINDOW_MAX-2:0], 1'b1};
    assign pass_valid[WINDOW_MAX] = step && keep[WINDOW_MAX-1];
    assign pass_value[WINDOW_MAX] = i_sample;
    assign pass_age[WINDOW_MAX]   = '0;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_WIDTH    (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_sample      (i_sample),
            .i_window      (win),
            .i_prev_keep   (prev_keep[g]),
            .i_right_valid (pass_valid[g+1]),
            .i_right_value (pass_value[g+1]),
            .i_right_age   (pass_age[g+1]),
            .o_keep        (keep[g]),
            .o_stale       (stale[g]),
            .o_expire      (expire[g]),
            .o_pass_valid  (pass_valid[g]),
            .o_pass_value  (pass_value[g]),
            .o_pass_age    (pass_age[g]),
            .o_next_value  (next_value[g])
        );
    end

    // Count samples of the current sequence, saturating at the window
    always_comb begin
        seen_base = i_starts_sequence ? '0 : r_seen;
        n_seen    = (seen_base < win) ? seen_base + CW'(1) : seen_base;
    end

    assign emit = step && (n_seen >= win);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (step) begin
            r_seen <= n_seen;
        end
    end

    // Buffer the new front value as the result
    swm_obuf #(
        .DATA_WIDTH (SAMPLE_WIDTH)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_data  (next_value[0]),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_window_max)
    );

    // A new sequence restarts the sample count at one
    a_seq_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_starts_sequence) |=> (r_seen == CW'(1)))
        else $error("sample count not restarted by a new sequence");

    // Every emitted result shows up on the result channel
    a_emit_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_valid)
        else $error("emitted result not presented");

    // With an empty buffer the emitted front value is presented next
    a_emit_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !o_valid) |=> (o_window_max == $past(next_value[0])))
        else $error("result value differs from queue front");

endmodule
